FILE: hw/rtl/pre_pkg.sv
// Shared types and constants for the printable run extractor.
// No dependencies; every other RTL file of the block but pre_stream_if imports this package.
package pre_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SPLIT_W   = 12;
  localparam int unsigned RUN_CNT_W = 13;

  // Defaults.
  localparam int unsigned MIN_RUN_DEF = 4;
  localparam logic [SPLIT_W-1:0] SPLIT_RESET = 12'd512;

  // Printable ASCII range, inclusive.
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  // Result kinds.
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // One input item.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } pre_in_t;

  // One result item.
  typedef struct packed {
    logic              item_kind;
    logic [BYTE_W-1:0] char_value;
    logic              last_of_burst;
  } pre_out_t;

  // Configuration write data.
  typedef logic [SPLIT_W-1:0] pre_cfg_t;

  // Status of one step from the burst generator.
  typedef struct packed {
    logic close;
    logic marker;
  } pre_gen_stat_t;

endpackage

FILE: hw/rtl/pre_stream_if.sv
// Valid/ready channel used for the input, result and configuration ports.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface pre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/printable_run_extractor_unit.sv
// Top level of the printable run extractor: input register, run state, burst buffer.
// Depends on pre_pkg, pre_stream_if, pre_burst_gen and pre_burst_buf.
//
//   Port     Dir  Payload                                   Transfer
//   in_if    in   data_byte, end_of_buffer                  one byte of the buffer
//   out_if   out  item_kind, char_value, last_of_burst      one result
//   cfg_if   in   split_length (12 bits)                    register write
//
// One byte is taken per cycle while the burst buffer is free; the result burst of a
// byte (up to MinRun+1 results) leaves one result per cycle while out_if is ready;
// a one-result byte keeps the full rate, a longer burst holds input until it drains.
// A byte waits in the input register while the buffer still holds an older burst.
// Reset clears the run length, the buffers and sets split_length to 512.
module printable_run_extractor_unit #(
  parameter int unsigned MinRun = pre_pkg::MIN_RUN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pre_stream_if.sink   in_if,
  pre_stream_if.source out_if,
  pre_stream_if.sink   cfg_if
);
  import pre_pkg::*;

  localparam int unsigned MaxBurst = MinRun + 1;
  localparam int unsigned HeldN    = (MinRun > 1) ? MinRun - 1 : 1;
  localparam int unsigned CntW     = $clog2(MaxBurst + 1);

  logic                 inq_valid_q;
  pre_in_t              inq_data_q;
  logic [SPLIT_W-1:0]   split_q;
  logic [RUN_CNT_W-1:0] run_count_q, run_count_d;
  logic [BYTE_W-1:0]    held_q [HeldN];
  logic [BYTE_W-1:0]    held_d [HeldN];
  logic [CntW-1:0]      gen_cnt;
  logic                 gen_kind [MaxBurst];
  logic [BYTE_W-1:0]    gen_char [MaxBurst];
  pre_gen_stat_t        gen_stat;
  logic                 buf_free;
  logic [CntW-1:0]      buf_cnt;
  pre_out_t             buf_head;
  logic                 load;
  logic                 in_xfer;
  logic                 out_xfer;

  // Handshakes.
  assign load          = inq_valid_q && buf_free;
  assign in_if.ready   = !inq_valid_q || buf_free;
  assign in_xfer       = in_if.valid && in_if.ready;
  assign out_if.valid  = (buf_cnt != '0);
  assign out_if.data   = buf_head;
  assign out_xfer      = out_if.valid && out_if.ready;
  assign cfg_if.ready  = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_xfer) begin
      inq_valid_q <= 1'b1;
    end else if (load) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      inq_data_q <= in_if.data;
    end
  end

  // Split length register and run length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q     <= SPLIT_RESET;
      run_count_q <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        split_q <= cfg_if.data;
      end
      if (load) begin
        run_count_q <= run_count_d;
      end
    end
  end

  // Held-back characters; each is written before it is read within a run.
  always_ff @(posedge clk_i) begin
    if (load) begin
      held_q <= held_d;
    end
  end

  pre_burst_gen #(
    .MinRun (MinRun)
  ) u_gen (
    .data_byte_i     (inq_data_q.data_byte),
    .end_of_buffer_i (inq_data_q.end_of_buffer),
    .split_length_i  (split_q),
    .run_count_i     (run_count_q),
    .held_i          (held_q),
    .held_o          (held_d),
    .run_count_o     (run_count_d),
    .burst_cnt_o     (gen_cnt),
    .burst_kind_o    (gen_kind),
    .burst_char_o    (gen_char),
    .stat_o          (gen_stat)
  );

  pre_burst_buf #(
    .Depth (MaxBurst)
  ) u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_cnt_i  (gen_cnt),
    .load_kind_i (gen_kind),
    .load_char_i (gen_char),
    .pop_i       (out_xfer),
    .free_o      (buf_free),
    .cnt_o       (buf_cnt),
    .head_o      (buf_head)
  );

  // The burst buffer never holds more than one full burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_cnt <= CntW'(MaxBurst))
    else $error("burst buffer overfilled");

  // A closed run starts over at length zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && gen_stat.close |=> run_count_q == '0)
    else $error("run length not cleared after close");

  // An end marker always reaches the result side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && gen_stat.marker |=> out_if.valid)
    else $error("end marker lost");

  // A byte is never taken while the input register holds one that cannot move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inq_valid_q && (buf_cnt > CntW'(1)) |-> !in_xfer)
    else $error("input register overwritten");

endmodule

FILE: hw/rtl/pre_burst_gen.sv
// Combinational step logic: turns one byte and the run state into a burst of results.
// Depends on pre_pkg.
module pre_burst_gen #(
  parameter int unsigned MinRun = pre_pkg::MIN_RUN_DEF,
  localparam int unsigned MaxBurst = MinRun + 1,
  localparam int unsigned HeldN = (MinRun > 1) ? MinRun - 1 : 1,
  localparam int unsigned CntW = $clog2(MaxBurst + 1)
) (
  input  logic [pre_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          end_of_buffer_i,
  input  logic [pre_pkg::SPLIT_W-1:0]   split_length_i,
  input  logic [pre_pkg::RUN_CNT_W-1:0] run_count_i,
  input  logic [pre_pkg::BYTE_W-1:0]    held_i [HeldN],
  output logic [pre_pkg::BYTE_W-1:0]    held_o [HeldN],
  output logic [pre_pkg::RUN_CNT_W-1:0] run_count_o,
  output logic [CntW-1:0]               burst_cnt_o,
  output logic                          burst_kind_o [MaxBurst],
  output logic [pre_pkg::BYTE_W-1:0]    burst_char_o [MaxBurst],
  output pre_pkg::pre_gen_stat_t        stat_o
);
  import pre_pkg::*;

  localparam int unsigned HeldIdxW = (HeldN > 1) ? $clog2(HeldN) : 1;

  logic                 printable;
  logic [RUN_CNT_W-1:0] rc_char;
  logic                 pass_char;
  logic                 release_held;
  logic                 close;
  logic                 marker;
  logic [CntW-1:0]      chars_n;
  logic [CntW-1:0]      char_pos;

  // Classify the byte and work out where the run stands after it.
  always_comb begin
    printable    = (data_byte_i >= PRINT_LO) && (data_byte_i <= PRINT_HI);
    rc_char      = printable ? run_count_i + RUN_CNT_W'(1) : run_count_i;
    pass_char    = printable && (run_count_i >= RUN_CNT_W'(MinRun - 1));
    release_held = printable && (run_count_i == RUN_CNT_W'(MinRun - 1));
    // A run closes on a non-printable byte, on a split, or at the end of the buffer.
    close        = !printable || end_of_buffer_i || (rc_char > {1'b0, split_length_i});
    marker       = close && (rc_char >= RUN_CNT_W'(MinRun));
    run_count_o  = close ? '0 : rc_char;
    char_pos     = release_held ? CntW'(MinRun - 1) : '0;
    if (release_held) begin
      chars_n = CntW'(MinRun);
    end else if (pass_char) begin
      chars_n = CntW'(1);
    end else begin
      chars_n = '0;
    end
    burst_cnt_o = chars_n + CntW'(marker);
    stat_o      = '{close: close, marker: marker};
  end

  // Lay out the burst: held characters, then the current one, then the end marker.
  always_comb begin
    for (int j = 0; j < MaxBurst; j++) begin
      burst_kind_o[j] = KIND_CHAR;
      burst_char_o[j] = '0;
      if (release_held && (j < MinRun - 1)) begin
        burst_char_o[j] = held_i[j];
      end else if (pass_char && (CntW'(j) == char_pos)) begin
        burst_char_o[j] = data_byte_i;
      end else if (marker && (CntW'(j) == chars_n)) begin
        burst_kind_o[j] = KIND_MARKER;
      end
    end
  end

  // Hold back the first characters of a run until it qualifies.
  always_comb begin
    held_o = held_i;
    if (printable && (run_count_i < RUN_CNT_W'(MinRun - 1))) begin
      held_o[run_count_i[HeldIdxW-1:0]] = data_byte_i;
    end
  end

endmodule

FILE: hw/rtl/pre_burst_buf.sv
// Burst buffer: holds the results of one step and hands them out one per transfer.
// Depends on pre_pkg.
module pre_burst_buf #(
  parameter int unsigned Depth = pre_pkg::MIN_RUN_DEF + 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [CntW-1:0]            load_cnt_i,
  input  logic                       load_kind_i [Depth],
  input  logic [pre_pkg::BYTE_W-1:0] load_char_i [Depth],
  input  logic                       pop_i,
  output logic                       free_o,
  output logic [CntW-1:0]            cnt_o,
  output pre_pkg::pre_out_t          head_o
);
  import pre_pkg::*;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              kind_q [Depth];
  logic [BYTE_W-1:0] char_q [Depth];

  // The buffer can take a new burst once the one it holds is gone or leaving now.
  always_comb begin
    free_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop_i);
    cnt_o  = cnt_q;
    head_o = '{item_kind: kind_q[0], char_value: char_q[0],
               last_of_burst: (cnt_q == CntW'(1))};
    if (load_i) begin
      cnt_d = load_cnt_i;
    end else if (pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // Fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Entries: load a whole burst, or shift toward the head on each transfer.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= load_kind_i;
      char_q <= load_char_i;
    end else if (pop_i) begin
      for (int i = 0; i < Depth - 1; i++) begin
        kind_q[i] <= kind_q[i+1];
        char_q[i] <= char_q[i+1];
      end
    end
  end

endmodule
